### rtl/ready_queue_policy_selector_top_assert.svh
// Assertion macros for the ready queue policy selector.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef READY_QUEUE_POLICY_SELECTOR_TOP_ASSERT_SVH
`define READY_QUEUE_POLICY_SELECTOR_TOP_ASSERT_SVH

// Check an implication at every clock edge outside reset.
`define RQPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in the next cycle follows a condition now.
`define RQPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

### rtl/rqps_pkg.sv
// Shared types and codes for the ready queue policy selector.
// No dependencies.
package rqps_pkg;
	localparam int WORD_W = 16;
	localparam int OCC_W  = 5;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_DISPATCH = 2'd1;
	localparam logic [1:0] ACT_TICK     = 2'd2;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_HRRN = 2'd1;
	localparam logic [1:0] POL_SJF  = 2'd2;

	localparam logic [2:0] ADDR_POLICY = 3'd0;

	typedef struct packed {
		word_t id;
		word_t burst;
		word_t wait_cnt;
	} entry_t;
endpackage

### rtl/rqps_if.sv
// Request and response channel interfaces for the ready queue policy selector.
// Depends on rqps_pkg.
interface rqps_req_if import rqps_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] action;
	word_t      job_id;
	word_t      burst_length;

	modport source (output valid, action, job_id, burst_length, input ready);
	modport sink (input valid, action, job_id, burst_length, output ready);
endinterface

interface rqps_rsp_if import rqps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             granted;
	word_t            granted_id;
	word_t            granted_burst;
	word_t            granted_wait;
	logic             dropped;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, granted, granted_id, granted_burst, granted_wait,
		dropped, occupancy, input ready);
	modport sink (input valid, granted, granted_id, granted_burst, granted_wait,
		dropped, occupancy, output ready);
endinterface

### rtl/rqps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rqps_pkg.
module rqps_div import rqps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t dividend,
	input  word_t divisor,
	output logic  done,
	output word_t quotient
);
	localparam int CNT_W = $clog2(WORD_W + 1);

	logic [WORD_W:0] rem_q;
	logic [WORD_W:0] rem_sh;
	logic [WORD_W:0] rem_nx;
	word_t           quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            ge;

	assign rem_sh = {rem_q[WORD_W-1:0], quo_q[WORD_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[WORD_W-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### rtl/ready_queue_policy_selector_top.sv
// Ready table of up to TABLE_DEPTH jobs in arrival order, kept in one synchronous
// memory (one write and one registered read per cycle). Every item gives one result.
// An insert goes from idle straight to the output stage. A dispatch scans the table
// one entry at a time, read then evaluated (first in first out reads entry 0 only);
// under highest response ratio each entry with a nonzero burst also waits for the
// bit-serial divider. Removing entry p then moves the later entries down one at a
// time, each read then written back. A tick under highest response ratio rewrites
// every entry, each read then written back. Depends on rqps_pkg, rqps_if and
// rqps_div.
module ready_queue_policy_selector_top import rqps_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rqps_req_if.sink    req,
	rqps_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DIV, S_SH_RD, S_SH_WR, S_TK_RD, S_TK_WR, S_OUT
	} state_t;

	state_t           state_q;
	entry_t           mem [TABLE_DEPTH];
	entry_t           rd_data_q;
	entry_t           wr_data;
	entry_t           best_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pick_q;
	logic [IDX_W-1:0] pick_c;
	logic             wr_en;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   idx_p1;
	logic [CNT_W:0]   idx_p2;
	logic [CNT_W:0]   pick_p1;
	logic [1:0]       policy_q;
	logic [WORD_W:0]  key_q;
	logic [WORD_W:0]  key_c;
	logic             better_c;
	logic             eval_c;
	logic             scan_more;
	logic             div_start;
	logic             div_done;
	word_t            div_quo;
	logic             res_granted_q;
	logic             res_dropped_q;
	logic             ovalid_q;
	logic             o_granted_q;
	word_t            o_id_q;
	word_t            o_burst_q;
	word_t            o_wait_q;
	logic             o_dropped_q;
	logic [OCC_W-1:0] o_occ_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	rqps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data_q.wait_cnt),
		.divisor  (rd_data_q.burst),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign idx_p1  = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);
	assign idx_p2  = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
	assign rd_addr = (state_q == S_SH_RD) ? idx_q + IDX_W'(1) : idx_q;

	assign div_start = (state_q == S_SCAN_EV) && (policy_q == POL_HRRN) &&
		(rd_data_q.burst != '0);
	assign eval_c    = ((state_q == S_SCAN_EV) && !div_start) ||
		((state_q == S_DIV) && div_done);
	assign key_c     = (rd_data_q.burst == '0) ? {1'b1, {WORD_W{1'b0}}} : {1'b0, div_quo};
	assign scan_more = (idx_p1 < {1'b0, count_q}) &&
		((policy_q == POL_HRRN) || (policy_q == POL_SJF));

	always_comb begin
		priority if (idx_q == '0) begin
			better_c = 1'b1;
		end else if (policy_q == POL_HRRN) begin
			better_c = key_c > key_q;
		end else if (policy_q == POL_SJF) begin
			better_c = rd_data_q.burst < best_q.burst;
		end else begin
			better_c = 1'b0;
		end
	end

	assign pick_c  = better_c ? idx_q : pick_q;
	assign pick_p1 = (CNT_W+1)'(pick_c) + (CNT_W+1)'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		unique case (state_q)
			S_IDLE: begin
				wr_en   = req.valid && (req.action == ACT_INSERT) &&
					(count_q < CNT_W'(TABLE_DEPTH));
				wr_addr = count_q[IDX_W-1:0];
				wr_data = '{id: req.job_id, burst: req.burst_length, wait_cnt: '0};
			end
			S_SH_WR: begin
				wr_en = 1'b1;
			end
			S_TK_WR: begin
				wr_en = 1'b1;
				if (rd_data_q.wait_cnt != '1) begin
					wr_data.wait_cnt = rd_data_q.wait_cnt + WORD_W'(1);
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			pick_q        <= '0;
			count_q       <= '0;
			key_q         <= '0;
			best_q        <= '0;
			res_granted_q <= 1'b0;
			res_dropped_q <= 1'b0;
			ovalid_q      <= 1'b0;
			o_granted_q   <= 1'b0;
			o_id_q        <= '0;
			o_burst_q     <= '0;
			o_wait_q      <= '0;
			o_dropped_q   <= 1'b0;
			o_occ_q       <= '0;
		end else begin
			if (ovalid_q && rsp.ready && (state_q != S_OUT)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_granted_q <= 1'b0;
						res_dropped_q <= 1'b0;
						idx_q         <= '0;
						state_q       <= S_OUT;
						unique case (req.action)
							ACT_INSERT: begin
								if (count_q >= CNT_W'(TABLE_DEPTH)) begin
									res_dropped_q <= 1'b1;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_DISPATCH: begin
								if (count_q != '0) begin
									state_q <= S_SCAN_RD;
								end
							end
							ACT_TICK: begin
								if ((policy_q == POL_HRRN) && (count_q != '0)) begin
									state_q <= S_TK_RD;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_EV;
				end
				S_SCAN_EV, S_DIV: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else if (eval_c) begin
						if (better_c) begin
							best_q <= rd_data_q;
							key_q  <= key_c;
							pick_q <= idx_q;
						end
						if (scan_more) begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_SCAN_RD;
						end else begin
							idx_q <= pick_c;
							if (pick_p1 < {1'b0, count_q}) begin
								state_q <= S_SH_RD;
							end else begin
								count_q       <= count_q - CNT_W'(1);
								res_granted_q <= 1'b1;
								state_q       <= S_OUT;
							end
						end
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_p2 < {1'b0, count_q}) begin
						state_q <= S_SH_RD;
					end else begin
						count_q       <= count_q - CNT_W'(1);
						res_granted_q <= 1'b1;
						state_q       <= S_OUT;
					end
				end
				S_TK_RD: begin
					state_q <= S_TK_WR;
				end
				S_TK_WR: begin
					idx_q <= idx_q + IDX_W'(1);
					state_q <= (idx_p1 < {1'b0, count_q}) ? S_TK_RD : S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q    <= 1'b1;
						o_granted_q <= res_granted_q;
						o_id_q      <= res_granted_q ? best_q.id : '0;
						o_burst_q   <= res_granted_q ? best_q.burst : '0;
						o_wait_q    <= res_granted_q ? best_q.wait_cnt : '0;
						o_dropped_q <= res_dropped_q;
						o_occ_q     <= OCC_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
		end else if (psel && penable && pwrite && (paddr == ADDR_POLICY)) begin
			policy_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr == ADDR_POLICY) ? {30'b0, policy_q} : '0;
	assign pready = 1'b1;

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = ovalid_q;
	assign rsp.granted       = o_granted_q;
	assign rsp.granted_id    = o_id_q;
	assign rsp.granted_burst = o_burst_q;
	assign rsp.granted_wait  = o_wait_q;
	assign rsp.dropped       = o_dropped_q;
	assign rsp.occupancy     = o_occ_q;
endmodule

### rtl/rqps_chk.sv
// Port checker for the ready queue policy selector, bound to the top level.
// Depends on ready_queue_policy_selector_top_assert.svh.
`include "ready_queue_policy_selector_top_assert.svh"

module rqps_chk #(
	parameter int TABLE_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_granted,
	input logic [15:0] rsp_granted_id,
	input logic [15:0] rsp_granted_wait,
	input logic        rsp_dropped,
	input logic [4:0]  rsp_occupancy
);
	`RQPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")
	`RQPS_ASSERT(a_excl, rsp_valid |-> !(rsp_granted && rsp_dropped), "grant and drop together")
	`RQPS_ASSERT(a_zero, rsp_valid && !rsp_granted |-> rsp_granted_id == 16'd0 && rsp_granted_wait == 16'd0, "fields nonzero without grant")
	`RQPS_ASSERT(a_full, rsp_valid && rsp_dropped |-> rsp_occupancy == 5'(TABLE_DEPTH), "drop with table not full")
endmodule

bind ready_queue_policy_selector_top rqps_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_rqps_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_granted      (rsp.granted),
	.rsp_granted_id   (rsp.granted_id),
	.rsp_granted_wait (rsp.granted_wait),
	.rsp_dropped      (rsp.dropped),
	.rsp_occupancy    (rsp.occupancy)
);
